### rtl/rvm_pkg.sv
// ----------------------------------------------------------------------------
// rvm_pkg
// Shared types and constants of the register machine execute unit: opcodes,
// fault codes and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package rvm_pkg;

  localparam int WORD_W  = 32;
  localparam int OP_W    = 8;
  localparam int RIDX_W  = 8;
  localparam int IMM_W   = 16;
  localparam int WIDX_W  = 5;
  localparam int FAULT_W = 2;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [OP_W-1:0]    opcode_t;
  typedef logic [RIDX_W-1:0]  ridx_t;
  typedef logic [FAULT_W-1:0] fault_t;

  localparam opcode_t OP_HALT  = 8'd0;
  localparam opcode_t OP_LOADI = 8'd1;
  localparam opcode_t OP_ADD   = 8'd2;
  localparam opcode_t OP_SUB   = 8'd3;
  localparam opcode_t OP_MULT  = 8'd4;
  localparam opcode_t OP_DIV   = 8'd5;
  localparam opcode_t OP_AND   = 8'd6;
  localparam opcode_t OP_LESS  = 8'd11;
  localparam opcode_t OP_LEQ   = 8'd12;
  localparam opcode_t OP_EQ    = 8'd13;
  localparam opcode_t OP_STORE = 8'd14;

  localparam fault_t FAULT_NONE = 2'd0;
  localparam fault_t FAULT_IDX  = 2'd1;
  localparam fault_t FAULT_DIV0 = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the accepted instruction word
    logic exec;       // evaluate the instruction into the result registers
    logic div_start;  // launch the divider
    logic div_cap;    // take the quotient
    logic commit;     // write back and present the result
  } rvm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_go;     // instruction needs the divider
    logic div_done;
    logic out_free;   // output register can take a new result
  } rvm_sts_t;

endpackage

### rtl/rvm_if.sv
// ----------------------------------------------------------------------------
// rvm_in_if / rvm_out_if
// Valid/ready channels of the execute unit: instruction items in, result
// items out.
// ----------------------------------------------------------------------------
interface rvm_in_if;
  import rvm_pkg::*;

  logic  valid;
  logic  ready;
  word_t instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface rvm_out_if;
  import rvm_pkg::*;

  logic              valid;
  logic              ready;
  logic              halted;
  logic              wrote;
  logic [WIDX_W-1:0] write_index;
  word_t             write_value;
  fault_t            fault_code;

  modport source (output valid, output halted, output wrote, output write_index,
                  output write_value, output fault_code, input ready);
  modport sink   (input valid, input halted, input wrote, input write_index,
                  input write_value, input fault_code, output ready);
endinterface

### rtl/register_vm_execute_unit.sv
// Each item passes through the states accept, read operands, execute, an optional
// divide and write back; a new item is taken only after the last one is written
// back. The one-bit-per-cycle divider loop sets the worst case.
// A new item is taken while the previous result still waits in the output
// register. Synchronous active-low reset clears the register file valid bits
// (all registers read as zero), the halt flag and the control state.
// ----------------------------------------------------------------------------
// register_vm_execute_unit
// Executes one register machine instruction word per item on a register file
// and reports the register write and fault code.
// ----------------------------------------------------------------------------
module register_vm_execute_unit #(
  parameter int REG_COUNT = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  rvm_in_if.sink   in_ch,
  rvm_out_if.source out_ch
);
  import rvm_pkg::*;

  rvm_cmd_t cmd;
  rvm_sts_t sts;

  rvm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rvm_dp #(
    .REG_COUNT (REG_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_word         (in_ch.instruction_word),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_halted      (out_ch.halted),
    .out_wrote       (out_ch.wrote),
    .out_write_index (out_ch.write_index),
    .out_write_value (out_ch.write_value),
    .out_fault_code  (out_ch.fault_code)
  );

endmodule

### rtl/rvm_div.sv
// ----------------------------------------------------------------------------
// rvm_div
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rvm_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  rvm_pkg::word_t dividend,
  input  rvm_pkg::word_t divisor,
  output logic          done,
  output rvm_pkg::word_t quotient
);
  import rvm_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  word_t            rem_r, rem_nxt;
  word_t            quo_r, quo_nxt;
  word_t            dvs_r, dvs_nxt;
  logic [WORD_W:0]  rem_sh;
  logic [WORD_W:0]  diff;

  // remainder stays below the divisor, so the shifted value fits one extra bit
  assign rem_sh = {rem_r, quo_r[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[WORD_W]) begin
        rem_nxt = diff[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/rvm_ctrl.sv
// ----------------------------------------------------------------------------
// rvm_ctrl
// Sequencer of the execute unit: accept, read operands, execute, optional
// divide, write back.
// ----------------------------------------------------------------------------
module rvm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rvm_pkg::rvm_sts_t sts,
  output rvm_pkg::rvm_cmd_t cmd
);
  import rvm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.div_go) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/rvm_dp.sv
// ----------------------------------------------------------------------------
// rvm_dp
// Datapath: instruction register, register file with two registered read
// ports, ALU, divider and the output register.
// ----------------------------------------------------------------------------
module rvm_dp #(
  parameter int REG_COUNT = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rvm_pkg::rvm_cmd_t             cmd,
  output rvm_pkg::rvm_sts_t             sts,
  input  rvm_pkg::word_t                in_word,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_halted,
  output logic                          out_wrote,
  output logic [rvm_pkg::WIDX_W-1:0]    out_write_index,
  output rvm_pkg::word_t                out_write_value,
  output rvm_pkg::fault_t               out_fault_code
);
  import rvm_pkg::*;

  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [RIDX_W:0] REG_LIM = (RIDX_W + 1)'(REG_COUNT);

  // instruction register
  opcode_t op_r;
  ridx_t   r1_r, r2_r, r3_r;

  // register file
  word_t                mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  word_t                rd_a_r, rd_b_r;
  logic                 rd_a_vld_r, rd_b_vld_r;
  ridx_t                addr_a;
  word_t                opa, opb;

  // execute results
  logic                 res_wr_r, res_halt_r;
  ridx_t                res_idx_r;
  word_t                res_val_r;
  fault_t               res_fault_r;
  logic                 ex_wr, ex_halt, ex_div;
  ridx_t                ex_idx;
  word_t                ex_val;
  fault_t               ex_fault;
  logic [RIDX_W:0]      dst;
  logic                 ok1, ok2, ok3, ok_dst;

  logic                 halt_r;
  word_t                quotient;
  logic                 div_done;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_halted_r, out_wrote_r;
  logic [WIDX_W-1:0]    out_idx_r;
  word_t                out_val_r;
  fault_t               out_fault_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_word[31:24];
      r1_r <= in_word[23:16];
      r2_r <= in_word[15:8];
      r3_r <= in_word[7:0];
    end
  end

  // store reads its source through port a
  assign addr_a = (op_r == OP_STORE) ? r1_r : r2_r;

  always_ff @(posedge clk) begin
    rd_a_r     <= mem[addr_a[AW-1:0]];
    rd_b_r     <= mem[r3_r[AW-1:0]];
    rd_a_vld_r <= vld_r[addr_a[AW-1:0]];
    rd_b_vld_r <= vld_r[r3_r[AW-1:0]];
    if (cmd.commit && res_wr_r) begin
      mem[res_idx_r[AW-1:0]] <= res_val_r;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.commit && res_wr_r) begin
      vld_r[res_idx_r[AW-1:0]] <= 1'b1;
    end
  end

  assign opa = rd_a_vld_r ? rd_a_r : '0;
  assign opb = rd_b_vld_r ? rd_b_r : '0;

  assign dst    = {1'b0, r2_r} + {1'b0, r3_r};
  assign ok1    = {1'b0, r1_r} < REG_LIM;
  assign ok2    = {1'b0, r2_r} < REG_LIM;
  assign ok3    = {1'b0, r3_r} < REG_LIM;
  assign ok_dst = dst < REG_LIM;

  always_comb begin
    ex_wr    = 1'b0;
    ex_halt  = 1'b0;
    ex_div   = 1'b0;
    ex_idx   = '0;
    ex_val   = '0;
    ex_fault = FAULT_NONE;
    if (!halt_r) begin
      unique case (op_r) inside
        OP_HALT: begin
          ex_halt = 1'b1;
        end
        OP_LOADI: begin
          if (ok1) begin
            ex_wr  = 1'b1;
            ex_idx = r1_r;
            ex_val = {16'd0, r2_r, r3_r};
          end else begin
            ex_fault = FAULT_IDX;
          end
        end
        OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_AND, OP_LESS, OP_LEQ, OP_EQ: begin
          if (!(ok1 && ok2 && ok3)) begin
            ex_fault = FAULT_IDX;
          end else begin
            ex_wr  = 1'b1;
            ex_idx = r1_r;
            case (op_r)
              OP_ADD:  ex_val = opa + opb;
              OP_SUB:  ex_val = opa - opb;
              OP_MULT: ex_val = opa * opb;
              OP_AND:  ex_val = opa & opb;
              OP_LESS: ex_val = {31'd0, opa < opb};
              OP_LEQ:  ex_val = {31'd0, opa <= opb};
              OP_EQ:   ex_val = {31'd0, opa == opb};
              default: ex_val = '0;
            endcase
            if (op_r == OP_DIV) begin
              if (opb == '0) begin
                ex_wr    = 1'b0;
                ex_idx   = '0;
                ex_fault = FAULT_DIV0;
              end else begin
                ex_div = 1'b1;
              end
            end
          end
        end
        OP_STORE: begin
          if (ok1 && ok_dst) begin
            ex_wr  = 1'b1;
            ex_idx = dst[RIDX_W-1:0];
            ex_val = opa;
          end else begin
            ex_fault = FAULT_IDX;
          end
        end
        default: begin
          ex_wr = 1'b0;
        end
      endcase
    end
  end

  rvm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (opa),
    .divisor  (opb),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_wr_r    <= ex_wr;
      res_halt_r  <= ex_halt;
      res_idx_r   <= ex_idx;
      res_val_r   <= ex_val;
      res_fault_r <= ex_fault;
    end else if (cmd.div_cap) begin
      res_val_r <= quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_r <= 1'b0;
    end else if (cmd.commit && res_halt_r) begin
      halt_r <= 1'b1;
    end
  end

  assign sts.div_go   = ex_div;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_halted_r <= halt_r || res_halt_r;
      out_wrote_r  <= res_wr_r;
      out_idx_r    <= res_idx_r[WIDX_W-1:0];
      out_val_r    <= res_val_r;
      out_fault_r  <= res_fault_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_halted      = out_halted_r;
  assign out_wrote       = out_wrote_r;
  assign out_write_index = out_idx_r;
  assign out_write_value = out_val_r;
  assign out_fault_code  = out_fault_r;

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks register_vm_execute_unit. Instruction words go in over a valid/ready
// channel and every accepted one is run through a predictor that keeps its own
// copy of the register file and halt flag. Each result item is compared field
// by field with the oldest prediction. The run starts with hand-picked
// instructions, then goes through random programs under changing back-pressure,
// and ends with a halt and a few instructions that must have no effect.
// ----------------------------------------------------------------------------
module tb;
  import rvm_pkg::*;

  localparam int      REGS         = 32;
  localparam int      CYCLE_LIMIT  = 600000;
  localparam int      DRAIN_CYCLES = 60;
  localparam int      PHASE_ITEMS  = 500;
  localparam int      STALL_CYCLES = 400;
  localparam int      MAX_PRINTS   = 25;
  localparam ridx_t   RIDX_MAX     = 8'hFF;
  localparam opcode_t OP_EMPTY_LO  = 8'd7;
  localparam opcode_t OP_EMPTY_HI  = 8'd10;
  localparam opcode_t OP_UNKNOWN_LO = 8'd15;
  localparam opcode_t OP_UNKNOWN_HI = 8'hFF;

  typedef struct packed {
    logic              halted;
    logic              wrote;
    logic [WIDX_W-1:0] widx;
    word_t             wval;
    fault_t            fault;
  } exec_result_t;

  class exec_scoreboard;
    word_t        shadow_regs [REGS];
    logic         halted_seen;
    exec_result_t expected_results [$];
    int           errors;
    int           n_items;
    int           n_checked;
    int           n_writes;
    int           n_idx_faults;
    int           n_div_faults;

    function new();
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      halted_seen = 1'b0;
      errors = 0;
      n_items = 0;
      n_checked = 0;
      n_writes = 0;
      n_idx_faults = 0;
      n_div_faults = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // runs one accepted instruction on the shadow state
    function void note_instruction(word_t w);
      opcode_t      op;
      ridx_t        a, b, c;
      int unsigned  dst;
      word_t        x, y;
      exec_result_t r;
      op = w[31:24];
      a = w[23:16];
      b = w[15:8];
      c = w[7:0];
      dst = 0;
      r = '0;
      n_items++;
      if (!halted_seen) begin
        case (op)
          OP_HALT: halted_seen = 1'b1;
          OP_LOADI: begin
            if (a < REGS) begin
              r.wrote = 1'b1;
              dst = a;
              r.wval = {16'h0000, w[15:0]};
            end else begin
              r.fault = FAULT_IDX;
            end
          end
          OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_AND, OP_LESS, OP_LEQ, OP_EQ: begin
            if (a >= REGS || b >= REGS || c >= REGS) begin
              r.fault = FAULT_IDX;
            end else begin
              x = shadow_regs[b];
              y = shadow_regs[c];
              dst = a;
              r.wrote = 1'b1;
              case (op)
                OP_ADD:  r.wval = x + y;
                OP_SUB:  r.wval = x - y;
                OP_MULT: r.wval = x * y;
                OP_DIV: begin
                  if (y == '0) begin
                    r.wrote = 1'b0;
                    r.fault = FAULT_DIV0;
                  end else begin
                    r.wval = x / y;
                  end
                end
                OP_AND:  r.wval = x & y;
                OP_LESS: r.wval = word_t'(x < y);
                OP_LEQ:  r.wval = word_t'(x <= y);
                default: r.wval = word_t'(x == y);
              endcase
            end
          end
          OP_STORE: begin
            // destination is the sum of two indices, up to 510
            dst = b + c;
            if (a >= REGS || dst >= REGS) begin
              r.fault = FAULT_IDX;
            end else begin
              r.wrote = 1'b1;
              r.wval = shadow_regs[a];
            end
          end
          default: ;
        endcase
        if (r.wrote) begin
          shadow_regs[dst] = r.wval;
          r.widx = dst[WIDX_W-1:0];
        end else begin
          r.wval = '0;
        end
      end
      r.halted = halted_seen;
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("tb: mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(exec_result_t got);
      exec_result_t want;
      n_checked++;
      if (got.fault == FAULT_IDX) n_idx_faults++;
      if (got.fault == FAULT_DIV0) n_div_faults++;
      if (got.wrote) n_writes++;
      if (expected_results.size() == 0) begin
        report("result item with no instruction outstanding");
        return;
      end
      want = expected_results.pop_front();
      if (got.halted !== want.halted)
        report($sformatf("halted got %b want %b", got.halted, want.halted));
      if (got.wrote !== want.wrote)
        report($sformatf("wrote got %b want %b", got.wrote, want.wrote));
      if (got.widx !== want.widx)
        report($sformatf("write_index got %0d want %0d", got.widx, want.widx));
      if (got.wval !== want.wval)
        report($sformatf("write_value got %h want %h", got.wval, want.wval));
      if (got.fault !== want.fault)
        report($sformatf("fault_code got %0d want %0d", got.fault, want.fault));
    endtask

    task final_check();
      if (expected_results.size() != 0)
        report($sformatf("%0d results never arrived", expected_results.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   stall_left;
  int   cycles;

  exec_scoreboard sb;

  rvm_in_if  in_ch ();
  rvm_out_if out_ch ();

  register_vm_execute_unit #(.REG_COUNT(REGS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  opcode_t alu_ops [8] = '{OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_AND, OP_LESS, OP_LEQ, OP_EQ};

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  // result side: check accepted items, then choose ready for the next edge
  always @(posedge clk) begin
    exec_result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.halted = out_ch.halted;
        got.wrote  = out_ch.wrote;
        got.widx   = out_ch.write_index;
        got.wval   = out_ch.write_value;
        got.fault  = out_ch.fault_code;
        sb.check_result(got);
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic word_t pack_instr(opcode_t op, ridx_t a, ridx_t b, ridx_t c);
    return {op, a, b, c};
  endfunction

  function automatic word_t loadi_word(ridx_t a, logic [IMM_W-1:0] imm);
    return {OP_LOADI, a, imm};
  endfunction

  // mostly legal indices, now and then an out-of-range one from REGS up to RIDX_MAX
  function automatic ridx_t pick_idx();
    if ($urandom_range(99) < 8) return ridx_t'($urandom_range(RIDX_MAX, REGS));
    return ridx_t'($urandom_range(REGS - 1));
  endfunction

  function automatic word_t random_instr();
    int unsigned sel;
    ridx_t       a, b, c;
    opcode_t     op;
    word_t       w;
    sel = $urandom_range(99);
    a = pick_idx();
    b = pick_idx();
    c = ($urandom_range(9) == 0) ? b : pick_idx();
    if (sel < 14) begin
      w = loadi_word(a, IMM_W'($urandom));
    end else if (sel < 76) begin
      w = pack_instr(alu_ops[$urandom_range(7)], a, b, c);
    end else if (sel < 88) begin
      if ($urandom_range(3) == 0) begin
        b = ridx_t'($urandom);
        c = ridx_t'($urandom);
      end else begin
        b = ridx_t'($urandom_range(REGS - 1));
        c = ridx_t'($urandom_range(REGS - 1 - b));
      end
      w = pack_instr(OP_STORE, a, b, c);
    end else if (sel < 94) begin
      op = $urandom_range(1) ? opcode_t'($urandom_range(OP_EMPTY_HI, OP_EMPTY_LO))
                             : opcode_t'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));
      w = {op, 24'($urandom)};
    end else begin
      // raw noise, but never a halt while the run is still going
      w = $urandom;
      if (w[31:24] == OP_HALT) w[31:24] = OP_UNKNOWN_HI;
    end
    return w;
  endfunction

  task automatic send_word(word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.instruction_word <= $urandom;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.instruction_word <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_instruction(w);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random(int n);
    repeat (n) send_word(random_instr());
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cycles = 0;
    stall_left = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.instruction_word = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every operation, the fault cases
    send_word(loadi_word(8'd0, 16'hFFFF));
    send_word(loadi_word(8'd31, 16'h0001));
    send_word(pack_instr(OP_SUB, 8'd5, 8'd1, 8'd31));     // 0 - 1 wraps to all ones
    send_word(pack_instr(OP_MULT, 8'd6, 8'd5, 8'd5));
    send_word(pack_instr(OP_MULT, 8'd7, 8'd0, 8'd0));
    send_word(pack_instr(OP_ADD, 8'd8, 8'd5, 8'd31));     // wraps to zero
    send_word(pack_instr(OP_DIV, 8'd9, 8'd5, 8'd0));
    send_word(pack_instr(OP_DIV, 8'd10, 8'd5, 8'd2));     // divide by zero
    send_word(pack_instr(OP_DIV, 8'd200, 8'd5, 8'd2));    // index fault wins over div by zero
    send_word(pack_instr(OP_DIV, 8'd15, 8'd0, 8'd0));
    send_word(pack_instr(OP_AND, 8'd11, 8'd5, 8'd7));
    send_word(pack_instr(OP_LESS, 8'd12, 8'd31, 8'd5));
    send_word(pack_instr(OP_LEQ, 8'd13, 8'd5, 8'd5));
    send_word(pack_instr(OP_EQ, 8'd14, 8'd5, 8'd0));
    send_word(pack_instr(OP_STORE, 8'd5, 8'd15, 8'd16));
    send_word(pack_instr(OP_STORE, 8'd5, RIDX_MAX, RIDX_MAX));
    send_word(pack_instr(OP_STORE, 8'd32, 8'd0, 8'd0));
    send_word(loadi_word(RIDX_MAX, 16'h1234));
    send_word(pack_instr(OP_ADD, 8'd1, 8'd32, 8'd0));
    send_word({OP_EMPTY_LO, 24'($urandom)});
    send_word({OP_EMPTY_HI, 24'($urandom)});
    send_word({OP_UNKNOWN_LO, 24'($urandom)});
    send_word({OP_UNKNOWN_HI, 24'hFFFFFF});
    wait_drained();

    send_idle_pct = 23;
    recv_idle_pct = 49;
    send_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 49;
    recv_idle_pct = 23;
    send_random(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // hold the result side off long enough for the unit to back up
    stall_left <= STALL_CYCLES;
    send_random(40);
    send_random(PHASE_ITEMS - 40);
    wait_drained();

    // halt, then instructions that must leave everything alone
    send_word(pack_instr(OP_HALT, 8'd0, 8'd0, 8'd0));
    send_word(loadi_word(8'd3, 16'hBEEF));
    send_word(pack_instr(OP_DIV, 8'd4, 8'd5, 8'd2));
    send_word(pack_instr(OP_STORE, 8'd40, RIDX_MAX, RIDX_MAX));
    send_word(pack_instr(OP_HALT, 8'd1, 8'd2, 8'd3));
    send_word(pack_instr(OP_ADD, 8'd6, 8'd5, 8'd5));
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.final_check();

    $display("tb: %0d instructions sent, %0d results checked, %0d register writes",
             sb.n_items, sb.n_checked, sb.n_writes);
    $display("tb: %0d index faults, %0d divide-by-zero faults, halted at end: %b",
             sb.n_idx_faults, sb.n_div_faults, sb.halted_seen);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
